FILE: hdl/assert_macros.svh
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// Checked on every rising edge while reset is released.
`define ASSERT_RST(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
// Checked on every rising edge, reset included.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define ASSERT_RST(lbl, clk, rstn, prop, msg)
`define ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

FILE: hdl/rsame_pkg.sv
`default_nettype none

package rsame_pkg;

  localparam int VALUE_WIDTH = 31;
  localparam int TDATA_W     = ((VALUE_WIDTH + 7) / 8) * 8;
  localparam int APB_AW      = 3;
  localparam int APB_DW      = 32;

  // paddr[2] selects the register, low address bits are ignored
  localparam logic REG_EXPONENT = 1'b0;
  localparam logic REG_MODULUS  = 1'b1;

  typedef logic [VALUE_WIDTH-1:0] value_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RED,
    S_RED_W,
    S_STEP,
    S_MUL_W,
    S_SQR_W,
    S_DONE
  } state_e;

  typedef enum logic [1:0] {
    OP_REDUCE,
    OP_MUL,
    OP_SQR
  } op_e;

  typedef struct packed {
    logic load;
    logic start;
    op_e  op;
    logic shift_e;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic short_path;
    logic mm_done;
    logic e_lsb;
    logic e_last;
  } status_t;

endpackage

`default_nettype wire

FILE: hdl/rsame_mulmod.sv
`default_nettype none

`include "assert_macros.svh"

// Bit-serial interleaved modular multiply: p = a * b mod n, b scanned MSB first.
// Requires a < n (or a = 1), n != 0. a_i and n_i must hold steady while busy.
module rsame_mulmod (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire rsame_pkg::value_t a_i,
  input  wire rsame_pkg::value_t b_i,
  input  wire rsame_pkg::value_t n_i,
  output logic                   done_o,
  output rsame_pkg::value_t      p_o
);

  localparam int W    = rsame_pkg::VALUE_WIDTH;
  localparam int CntW = $clog2(W);

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  rsame_pkg::value_t r_q, r_d;
  rsame_pkg::value_t b_q, b_d;

  logic [W+1:0] x, x1, x2, n1, n2;
  logic         ge1, ge2;
  rsame_pkg::value_t r_next;

  // x = 2r + bit*a < 3n, so at most two subtractions of n
  always_comb begin
    n1  = {2'b00, n_i};
    n2  = {1'b0, n_i, 1'b0};
    x   = {1'b0, r_q, 1'b0} + (b_q[W-1] ? {2'b00, a_i} : '0);
    x1  = x - n1;
    x2  = x - n2;
    ge1 = (x >= n1);
    ge2 = (x >= n2);
    if (ge2) begin
      r_next = x2[W-1:0];
    end else if (ge1) begin
      r_next = x1[W-1:0];
    end else begin
      r_next = x[W-1:0];
    end
  end

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    r_d    = r_q;
    b_d    = b_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CntW'(W - 1);
      r_d    = '0;
      b_d    = b_i;
    end else if (busy_q) begin
      r_d   = r_next;
      b_d   = b_q << 1;
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    r_q <= r_d;
    b_q <= b_d;
  end

  assign done_o = done_q;
  assign p_o    = r_q;

  `ASSERT_RST(a_mm_no_restart, clk_i, rst_ni, start_i |-> !busy_q, "mulmod restarted while busy")
  `ASSERT_RST(a_mm_done_after_busy, clk_i, rst_ni, done_q |-> $past(busy_q), "spurious mulmod done")
  `ASSERT_RST(a_mm_reduced, clk_i, rst_ni, done_q |-> (r_q < n_i), "mulmod result not reduced")

endmodule

`default_nettype wire

FILE: hdl/rsame_dp.sv
`default_nettype none

module rsame_dp (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire rsame_pkg::cmd_t   cmd_i,
  input  wire rsame_pkg::value_t base_i,
  input  wire rsame_pkg::value_t exponent_i,
  input  wire rsame_pkg::value_t modulus_i,
  output rsame_pkg::status_t     status_o,
  output rsame_pkg::value_t      result_o
);

  localparam int W = rsame_pkg::VALUE_WIDTH;

  rsame_pkg::value_t acc_q, sq_q, base_q, n_q, e_q;
  rsame_pkg::op_e    op_q;

  rsame_pkg::value_t mm_a, mm_b, mm_p, acc_init;
  logic              mm_done;
  logic              exp_small, mod_zero;

  assign exp_small = (exponent_i[W-1:1] == '0);
  assign mod_zero  = (modulus_i == '0);

  // acc starts at the final answer for the short cases, else at 1 mod n
  always_comb begin
    if (exp_small) begin
      acc_init = base_i;
    end else if (mod_zero || modulus_i == rsame_pkg::value_t'(1)) begin
      acc_init = '0;
    end else begin
      acc_init = rsame_pkg::value_t'(1);
    end
  end

  // a is read only while the unit runs, so it follows the latched op
  always_comb begin
    case (op_q)
      rsame_pkg::OP_MUL:    mm_a = acc_q;
      rsame_pkg::OP_SQR:    mm_a = sq_q;
      rsame_pkg::OP_REDUCE: mm_a = rsame_pkg::value_t'(1);
      default:              mm_a = '0;
    endcase
  end

  // b is captured at start, so it follows the command
  always_comb begin
    case (cmd_i.op)
      rsame_pkg::OP_REDUCE: mm_b = base_q;
      rsame_pkg::OP_MUL:    mm_b = sq_q;
      rsame_pkg::OP_SQR:    mm_b = sq_q;
      default:              mm_b = '0;
    endcase
  end

  rsame_mulmod u_mulmod (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.start),
    .a_i     (mm_a),
    .b_i     (mm_b),
    .n_i     (n_q),
    .done_o  (mm_done),
    .p_o     (mm_p)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      base_q <= base_i;
      n_q    <= modulus_i;
      e_q    <= exponent_i;
      acc_q  <= acc_init;
    end else begin
      if (mm_done) begin
        if (op_q == rsame_pkg::OP_MUL) begin
          acc_q <= mm_p;
        end else begin
          sq_q <= mm_p;
        end
      end
      if (cmd_i.shift_e) begin
        e_q <= e_q >> 1;
      end
    end
    if (cmd_i.start) begin
      op_q <= cmd_i.op;
    end
  end

  assign status_o.short_path = exp_small || mod_zero;
  assign status_o.mm_done    = mm_done;
  assign status_o.e_lsb      = e_q[0];
  assign status_o.e_last     = (e_q[W-1:1] == '0);
  assign result_o            = acc_q;

endmodule

`default_nettype wire

FILE: hdl/rsame_ctrl.sv
`default_nettype none

module rsame_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               s_valid_i,
  input  wire logic               out_free_i,
  input  wire rsame_pkg::status_t status_i,
  output logic                    s_ready_o,
  output rsame_pkg::cmd_t         cmd_o
);

  rsame_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rsame_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // exponent scanned LSB first; the trailing square after the top bit is skipped
  always_comb begin
    state_d   = state_q;
    s_ready_o = 1'b0;
    cmd_o     = '0;
    cmd_o.op  = rsame_pkg::OP_REDUCE;
    case (state_q)
      rsame_pkg::S_IDLE: begin
        s_ready_o = 1'b1;
        if (s_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = status_i.short_path ? rsame_pkg::S_DONE : rsame_pkg::S_RED;
        end
      end
      rsame_pkg::S_RED: begin
        cmd_o.start = 1'b1;
        cmd_o.op    = rsame_pkg::OP_REDUCE;
        state_d     = rsame_pkg::S_RED_W;
      end
      rsame_pkg::S_RED_W: begin
        if (status_i.mm_done) begin
          state_d = rsame_pkg::S_STEP;
        end
      end
      rsame_pkg::S_STEP: begin
        cmd_o.start = 1'b1;
        if (status_i.e_lsb) begin
          cmd_o.op = rsame_pkg::OP_MUL;
          state_d  = rsame_pkg::S_MUL_W;
        end else begin
          cmd_o.op      = rsame_pkg::OP_SQR;
          cmd_o.shift_e = 1'b1;
          state_d       = rsame_pkg::S_SQR_W;
        end
      end
      rsame_pkg::S_MUL_W: begin
        if (status_i.mm_done) begin
          if (status_i.e_last) begin
            state_d = rsame_pkg::S_DONE;
          end else begin
            cmd_o.start   = 1'b1;
            cmd_o.op      = rsame_pkg::OP_SQR;
            cmd_o.shift_e = 1'b1;
            state_d       = rsame_pkg::S_SQR_W;
          end
        end
      end
      rsame_pkg::S_SQR_W: begin
        if (status_i.mm_done) begin
          state_d = rsame_pkg::S_STEP;
        end
      end
      rsame_pkg::S_DONE: begin
        if (out_free_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = rsame_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = rsame_pkg::S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: hdl/rsa_modular_exponentiation_core.sv
`default_nettype none

`include "assert_macros.svh"

// Modular exponentiation: each value on the input stream comes back as
// value^exponent mod modulus, one result per value, in order. exponent and
// modulus are to be written over APB (exponent at 0x0, modulus at 0x4, 31
// bits) only while the core is idle; the core itself does not enforce this. An
// exponent of 0 or 1 returns the value unchanged and unreduced; otherwise a
// modulus of 0 returns 0. The core takes one value at a time. Time is set by
// the bit-serial modular multiplier, which handles one multiplier bit per
// cycle. One multiply reduces the base, then each exponent bit below the top
// one costs a squaring and each set bit a multiply. The next value is accepted
// while a finished result waits downstream.
module rsa_modular_exponentiation_core (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  // APB configuration
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [rsame_pkg::APB_AW-1:0]   paddr,
  input  wire logic [rsame_pkg::APB_DW-1:0]   pwdata,
  output logic      [rsame_pkg::APB_DW-1:0]   prdata,
  output logic                                pready,
  // input stream
  input  wire logic                           s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  input  wire logic [rsame_pkg::TDATA_W-1:0]  s_axis_tdata_i,  // [30:0] base_value
  // result stream
  output logic                                m_axis_tvalid_o,
  input  wire logic                           m_axis_tready_i,
  output logic      [rsame_pkg::TDATA_W-1:0]  m_axis_tdata_o   // [30:0] result_value
);

  localparam int W = rsame_pkg::VALUE_WIDTH;

  rsame_pkg::value_t  exponent_q, modulus_q;
  rsame_pkg::value_t  result;
  rsame_pkg::value_t  m_data_q;
  logic               m_valid_q;
  logic               out_free;
  logic               cfg_wr;
  logic               reg_sel;
  logic               s_accept;
  rsame_pkg::value_t  rd_val;
  rsame_pkg::cmd_t    cmd;
  rsame_pkg::status_t status;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign reg_sel = paddr[2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exponent_q <= rsame_pkg::value_t'(1);
      modulus_q  <= rsame_pkg::value_t'(2);
    end else if (cfg_wr) begin
      if (reg_sel == rsame_pkg::REG_MODULUS) begin
        modulus_q <= pwdata[W-1:0];
      end else begin
        exponent_q <= pwdata[W-1:0];
      end
    end
  end

  assign rd_val = (reg_sel == rsame_pkg::REG_MODULUS) ? modulus_q : exponent_q;
  assign prdata = {{(rsame_pkg::APB_DW - W){1'b0}}, rd_val};

  rsame_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_valid_i  (s_axis_tvalid_i),
    .out_free_i (out_free),
    .status_i   (status),
    .s_ready_o  (s_axis_tready_o),
    .cmd_o      (cmd)
  );

  rsame_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .base_i     (s_axis_tdata_i[W-1:0]),
    .exponent_i (exponent_q),
    .modulus_i  (modulus_q),
    .status_o   (status),
    .result_o   (result)
  );

  // output register decouples the result from the next computation
  assign out_free = !m_valid_q || m_axis_tready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (cmd.out_load) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd.out_load) begin
      m_data_q <= result;
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = {{(rsame_pkg::TDATA_W - W){1'b0}}, m_data_q};

  assign s_accept = s_axis_tvalid_i && s_axis_tready_o;

  `ASSERT_RST(a_busy_after_accept, clk_i, rst_ni, s_accept |=> !s_axis_tready_o, "input accepted twice")
  `ASSERT_ALWAYS(a_no_valid_in_reset, clk_i, !rst_ni |-> !m_axis_tvalid_o, "result valid in reset")

endmodule

`default_nettype wire

FILE: tb/modexp_checker.sv
`timescale 1ns / 100ps

module modexp_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // APB register writes
  input  logic                          psel_i,
  input  logic                          penable_i,
  input  logic                          pwrite_i,
  input  logic                          pready_i,
  input  logic [rsame_pkg::APB_AW-1:0]  paddr_i,
  input  logic [rsame_pkg::APB_DW-1:0]  pwdata_i,
  // input stream
  input  logic                          s_tvalid_i,
  input  logic                          s_tready_i,
  input  logic [rsame_pkg::TDATA_W-1:0] s_tdata_i,
  // result stream
  input  logic                          m_tvalid_i,
  input  logic                          m_tready_i,
  input  logic [rsame_pkg::TDATA_W-1:0] m_tdata_i,
  output int                            fail_count_o,
  output int                            pending_o
);

  rsame_pkg::value_t exponent_cfg;
  rsame_pkg::value_t modulus_cfg;
  rsame_pkg::value_t awaited_powers[$];

  // base^ex mod md; products are kept at 64 bits so nothing overflows
  function automatic rsame_pkg::value_t modpow_result(input rsame_pkg::value_t base,
                                                      input rsame_pkg::value_t ex,
                                                      input rsame_pkg::value_t md);
    logic [63:0]       acc;
    logic [63:0]       sq;
    logic [63:0]       n;
    rsame_pkg::value_t bits_left;
    if (ex <= 1) return base;   // exponent zero or one: unreduced pass-through
    if (md == 0) return '0;
    n = {33'd0, md};
    acc = 64'd1 % n;
    sq = {33'd0, base} % n;
    bits_left = ex;
    while (bits_left != 0) begin
      if (bits_left[0]) acc = (acc * sq) % n;
      sq = (sq * sq) % n;
      bits_left = bits_left >> 1;
    end
    return acc[rsame_pkg::VALUE_WIDTH-1:0];
  endfunction

  task automatic report_mismatch(input string what);
    $display("%0t ns: mismatch: %s", $time, what);
    fail_count_o = fail_count_o + 1;
  endtask

  initial begin
    fail_count_o = 0;
    pending_o = 0;
  end

  always @(posedge clk_i or negedge rst_ni) begin
    rsame_pkg::value_t got;
    rsame_pkg::value_t want;
    if (!rst_ni) begin
      exponent_cfg = rsame_pkg::value_t'(1);
      modulus_cfg = rsame_pkg::value_t'(2);
      awaited_powers.delete();
      pending_o = 0;
    end else begin
      if (s_tvalid_i && s_tready_i) begin
        awaited_powers.push_back(modpow_result(s_tdata_i[rsame_pkg::VALUE_WIDTH-1:0],
                                               exponent_cfg, modulus_cfg));
      end
      if (m_tvalid_i && m_tready_i) begin
        got = m_tdata_i[rsame_pkg::VALUE_WIDTH-1:0];
        if (awaited_powers.size() == 0) begin
          report_mismatch($sformatf("result 0x%08h with no transaction pending", got));
        end else begin
          want = awaited_powers.pop_front();
          if (got !== want)
            report_mismatch($sformatf("result_value 0x%08h, expected 0x%08h (e=0x%08h n=0x%08h)",
                                      got, want, exponent_cfg, modulus_cfg));
        end
      end
      // config only changes while idle, so updating after the prediction is safe
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        if (paddr_i[2] == rsame_pkg::REG_MODULUS)
          modulus_cfg = pwdata_i[rsame_pkg::VALUE_WIDTH-1:0];
        else
          exponent_cfg = pwdata_i[rsame_pkg::VALUE_WIDTH-1:0];
      end
      pending_o = awaited_powers.size();
    end
  end

endmodule

FILE: tb/tb.sv
`timescale 1ns / 100ps

module tb;

  localparam logic [rsame_pkg::APB_AW-1:0] ADDR_EXPONENT = {rsame_pkg::REG_EXPONENT, 2'b00};
  localparam logic [rsame_pkg::APB_AW-1:0] ADDR_MODULUS  = {rsame_pkg::REG_MODULUS, 2'b00};
  localparam rsame_pkg::value_t            VALUE_MAX     = '1;
  localparam int                           RANDOM_ITEMS  = 290;
  localparam int                           CALM_AFTER    = 250;

  logic                            clk_i = 1'b0;
  logic                            rst_ni;
  logic                            psel;
  logic                            penable;
  logic                            pwrite;
  logic [rsame_pkg::APB_AW-1:0]    paddr;
  logic [rsame_pkg::APB_DW-1:0]    pwdata;
  logic [rsame_pkg::APB_DW-1:0]    prdata;
  logic                            pready;
  logic                            s_axis_tvalid;
  logic                            s_axis_tready;
  logic [rsame_pkg::TDATA_W-1:0]   s_axis_tdata;   // [30:0] base_value
  logic                            m_axis_tvalid;
  logic                            m_axis_tready;
  logic [rsame_pkg::TDATA_W-1:0]   m_axis_tdata;   // [30:0] result_value

  int fail_count;
  int pending;
  int stall_left = 0;
  bit calm = 1'b0;

  always #5 clk_i = ~clk_i;

  rsa_modular_exponentiation_core u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata)
  );

  modexp_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel_i       (psel),
    .penable_i    (penable),
    .pwrite_i     (pwrite),
    .pready_i     (pready),
    .paddr_i      (paddr),
    .pwdata_i     (pwdata),
    .s_tvalid_i   (s_axis_tvalid),
    .s_tready_i   (s_axis_tready),
    .s_tdata_i    (s_axis_tdata),
    .m_tvalid_i   (m_axis_tvalid),
    .m_tready_i   (m_axis_tready),
    .m_tdata_i    (m_axis_tdata),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // result side backpressure: tready dropped low in random bursts
  always @(negedge clk_i) begin
    if (calm) begin
      m_axis_tready <= 1'b1;
    end else if (stall_left > 0) begin
      m_axis_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 3) == 0) begin
      m_axis_tready <= 1'b0;
      stall_left <= $urandom_range(0, 10);
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  task automatic apb_write(input logic [rsame_pkg::APB_AW-1:0] addr,
                           input rsame_pkg::value_t value);
    @(negedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= {1'b0, value};
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // tvalid stays high after the transaction; callers lower it when idling
  task automatic send_base(input rsame_pkg::value_t base);
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {{(rsame_pkg::TDATA_W-rsame_pkg::VALUE_WIDTH){1'b0}}, base};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  task automatic sender_gap(input int cycles);
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    repeat (cycles - 1) @(negedge clk_i);
  endtask

  task automatic drain_results();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
  endtask

  task automatic set_key(input rsame_pkg::value_t ex, input rsame_pkg::value_t md);
    drain_results();
    apb_write(ADDR_EXPONENT, ex);
    apb_write(ADDR_MODULUS, md);
  endtask

  initial begin
    #40_000_000;
    $display("rsa_modular_exponentiation_core regression: fail");
    $finish;
  end

  initial begin
    rsame_pkg::value_t ex;
    rsame_pkg::value_t md;
    rsame_pkg::value_t base;
    logic [31:0]       low_mask;
    int                len;
    int                count;
    int                sent;
    rst_ni = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    m_axis_tready = 1'b0;
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;

    // reset key: exponent one passes values through
    send_base('0);
    send_base(VALUE_MAX);
    send_base(31'h2AAA_AAAA);
    // exponent zero behaves like one
    set_key('0, 31'd12345);
    send_base('0);
    send_base(VALUE_MAX);
    // modulus one and modulus zero give zero
    set_key(31'd2, 31'd1);
    send_base(31'd5);
    send_base(VALUE_MAX);
    set_key(31'd3, '0);
    send_base(31'h5555_5555);
    send_base(VALUE_MAX);
    // widest modulus
    set_key(31'd65537, VALUE_MAX);
    send_base('0);
    send_base(31'd1);
    send_base(VALUE_MAX);
    send_base(VALUE_MAX - 1'b1);
    set_key(VALUE_MAX, VALUE_MAX);
    send_base(31'd2);
    send_base(31'h7FFF_FFFD);
    set_key(31'd2, 31'd2);
    send_base(VALUE_MAX);
    // textbook key pair round trip
    set_key(31'd17, 31'd3233);
    send_base(31'd65);
    set_key(31'd2753, 31'd3233);
    send_base(31'd2790);

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      case ($urandom_range(0, 19))
        0: ex = rsame_pkg::value_t'($urandom_range(0, 1));
        1: ex = VALUE_MAX;
        default: begin
          len = $urandom_range(2, 31);
          low_mask = (32'd1 << len) - 32'd1;
          ex = rsame_pkg::value_t'(($urandom() & low_mask) | (32'd1 << (len - 1)));
        end
      endcase
      case ($urandom_range(0, 19))
        0: md = rsame_pkg::value_t'($urandom_range(0, 1));
        1: md = VALUE_MAX;
        2, 3: md = rsame_pkg::value_t'($urandom_range(2, 255));
        default: md = rsame_pkg::value_t'($urandom());
      endcase
      set_key(ex, md);
      count = $urandom_range(1, 24);
      for (int i = 0; i < count && sent < RANDOM_ITEMS; i++) begin
        case ($urandom_range(0, 15))
          0: base = '0;
          1: base = VALUE_MAX;
          2: base = md - 1'b1;
          3: base = md;
          default: base = rsame_pkg::value_t'($urandom());
        endcase
        if (!calm && $urandom_range(0, 2) == 0) sender_gap($urandom_range(1, 11));
        send_base(base);
        sent++;
        if (sent >= CALM_AFTER) calm = 1'b1;
      end
    end

    drain_results();
    // catch any stray result after the last one
    repeat (2100) @(negedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("rsa_modular_exponentiation_core regression: pass");
    end else begin
      $display("rsa_modular_exponentiation_core regression: fail");
    end
    $finish;
  end

endmodule
